>>> design/hbms_pkg.sv
`default_nettype none

package hbms_pkg;

  localparam int unsigned ADDR_BITS = 4;
  localparam int unsigned WORD_BITS = 4;
  localparam int unsigned MEM_DEPTH = 1 << ADDR_BITS;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [WORD_BITS-1:0] word_t;

  // Power-up contents, repeated every 16 words when the memory is deeper.
  localparam logic [3:0] INIT_TABLE [16] = '{
    4'd1, 4'd9, 4'd13, 4'd5, 4'd7, 4'd15, 4'd11, 4'd3,
    4'd2, 4'd10, 4'd14, 4'd6, 4'd4, 4'd12, 4'd8, 4'd0
  };

  typedef struct packed {
    logic       req;
    logic       rw;
    logic       ack_line;
    logic [3:0] data_in;
  } in_t;

  typedef struct packed {
    logic       ack_out;
    logic       data_drive;
    logic [3:0] data_out;
  } out_t;

  function automatic word_t init_word(addr_t idx);
    logic [3:0] low;
    low = 4'(idx);
    return WORD_BITS'(INIT_TABLE[low]);
  endfunction

endpackage

`default_nettype wire

>>> design/handshake_bus_memory_slave_top.sv
`default_nettype none

// Memory slave for a 4-bit shared-line bus with a REQ/ACK handshake. Each input
// transaction is one bus clock sample (REQ, R/W, ACK and the four data lines);
// each one yields exactly one output transaction with the ACK level, the data
// line enable and the driven word after that sample. A read drives the word
// fetched during the address phase once REQ drops; a write stores the data word,
// passes through a wait state and then acknowledges. The 16 x 4 memory powers up
// with a fixed table: per-word valid bits pick the table value until a word is
// written, so no init sweep is needed after reset.
// Throughput: one transaction per clock while in_ready_o is high; each result is
// registered into the output register, or the skid register if the output stalls.
// The address-phase memory read is registered into the fetched-word register in
// the same clock. A two-entry output stage (output register plus skid register)
// keeps in_ready_o high while a result waits; in_ready_o drops only when both are full.
module handshake_bus_memory_slave_top (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  wire hbms_pkg::in_t in_data_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output hbms_pkg::out_t   out_data_o
);

  // Handshake state.
  logic have_address_q, have_address_d;
  logic is_read_q, is_read_d;
  logic in_transfer_q, in_transfer_d;
  logic have_data_q, have_data_d;
  logic wait_left_q, wait_left_d;
  logic ack_q, ack_d;
  logic drive_q, drive_d;
  hbms_pkg::word_t drive_val_q, drive_val_d;
  hbms_pkg::addr_t addr_q, addr_d;
  hbms_pkg::word_t fetched_q;

  // Word memory with per-entry valid bits standing in for the init table.
  hbms_pkg::word_t mem_q [hbms_pkg::MEM_DEPTH];
  logic [hbms_pkg::MEM_DEPTH-1:0] mem_vld_q;

  // Output register and skid entry.
  hbms_pkg::out_t out_q, skid_q, res;
  logic out_valid_q, skid_valid_q;

  logic in_fire, out_fire;
  logic addr_phase, wr_store;
  hbms_pkg::addr_t in_addr;
  hbms_pkg::word_t in_word;

  assign in_ready_o  = !skid_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_fire    = out_valid_q && out_ready_i;

  assign in_addr = hbms_pkg::ADDR_BITS'(in_data_i.data_in);
  assign in_word = hbms_pkg::WORD_BITS'(in_data_i.data_in);

  // Bus step decode, in priority order.
  always_comb begin
    have_address_d = have_address_q;
    is_read_d      = is_read_q;
    in_transfer_d  = in_transfer_q;
    have_data_d    = have_data_q;
    wait_left_d    = wait_left_q;
    ack_d          = ack_q;
    drive_d        = drive_q;
    drive_val_d    = drive_val_q;
    addr_d         = addr_q;
    addr_phase     = 1'b0;
    wr_store       = 1'b0;
    if (wait_left_q) begin
      wait_left_d = 1'b0;
    end else if (!have_address_q && !have_data_q && !in_transfer_q && in_data_i.req) begin
      // Address phase: latch address and direction, fetch the word.
      have_address_d = 1'b1;
      is_read_d      = in_data_i.rw;
      addr_d         = in_addr;
      addr_phase     = 1'b1;
    end else if (have_address_q && !have_data_q && !in_transfer_q && in_data_i.req) begin
      if (!in_data_i.ack_line) begin
        ack_d = 1'b1;
      end else begin
        ack_d         = 1'b0;
        in_transfer_d = 1'b1;
      end
    end else if (have_address_q && !have_data_q && in_transfer_q && in_data_i.req &&
                 !in_data_i.ack_line && !is_read_q) begin
      // Write data phase, followed by a wait state.
      have_data_d = 1'b1;
      wr_store    = 1'b1;
      wait_left_d = 1'b1;
    end else if (have_address_q && have_data_q && in_transfer_q && in_data_i.req &&
                 !is_read_q) begin
      if (!in_data_i.ack_line) begin
        ack_d = 1'b1;
      end else begin
        ack_d          = 1'b0;
        have_address_d = 1'b0;
        have_data_d    = 1'b0;
        in_transfer_d  = 1'b0;
      end
    end else if (have_address_q && !have_data_q && in_transfer_q && !in_data_i.req &&
                 !in_data_i.ack_line && is_read_q) begin
      // Read data phase: put the fetched word on the lines with ACK.
      have_data_d = 1'b1;
      drive_d     = 1'b1;
      drive_val_d = fetched_q;
      ack_d       = 1'b1;
    end else if (have_address_q && have_data_q && in_transfer_q && in_data_i.req &&
                 in_data_i.ack_line && is_read_q) begin
      ack_d          = 1'b0;
      drive_d        = 1'b0;
      drive_val_d    = '0;
      have_address_d = 1'b0;
      have_data_d    = 1'b0;
      in_transfer_d  = 1'b0;
    end
  end

  always_comb begin
    res.ack_out    = ack_d;
    res.data_drive = drive_d;
    res.data_out   = drive_d ? 4'(drive_val_d) : 4'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_address_q <= 1'b0;
      is_read_q      <= 1'b0;
      in_transfer_q  <= 1'b0;
      have_data_q    <= 1'b0;
      wait_left_q    <= 1'b0;
      ack_q          <= 1'b0;
      drive_q        <= 1'b0;
      drive_val_q    <= '0;
      addr_q         <= '0;
      fetched_q      <= '0;
      mem_vld_q      <= '0;
    end else if (in_fire) begin
      have_address_q <= have_address_d;
      is_read_q      <= is_read_d;
      in_transfer_q  <= in_transfer_d;
      have_data_q    <= have_data_d;
      wait_left_q    <= wait_left_d;
      ack_q          <= ack_d;
      drive_q        <= drive_d;
      drive_val_q    <= drive_val_d;
      addr_q         <= addr_d;
      if (addr_phase) begin
        // Synchronous read, data registered.
        fetched_q <= mem_vld_q[in_addr] ? mem_q[in_addr] : hbms_pkg::init_word(in_addr);
      end
      if (wr_store) begin
        mem_vld_q[addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && wr_store) begin
      mem_q[addr_q] <= in_word;
    end
  end

  // Output register with skid entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire) begin
        out_q <= res;
      end
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

  // Checks.
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry full while output register empty");

  a_stall_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && out_valid_q && !out_ready_i) |=> skid_valid_q)
    else $error("result lost on output stall");

  a_wait_in_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wait_left_q |-> (have_data_q && !is_read_q && !drive_q))
    else $error("wait clock outside write data phase");

  a_drive_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drive_q |-> (is_read_q && have_data_q && in_transfer_q))
    else $error("data lines driven outside read data phase");

  a_data_needs_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_data_q |-> (in_transfer_q && have_address_q))
    else $error("data phase without address and transfer phase");

endmodule

`default_nettype wire
